/* rtl/lfp_pkg.sv */
package lfp_pkg;

  localparam int POINTS_PER_FRAME = 12;
  localparam int PT_IDX_W = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1;
  localparam int PT_NUM_W = 4;
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = 1;
  localparam int CMDQ_CNT_W = 2;

  localparam logic [7:0] HDR_BYTE     = 8'h54;
  localparam logic [2:0] VERSION_CODE = 3'd1;
  localparam logic [7:0] CRC_POLY     = 8'h4D;

  localparam logic [15:0] ANGLE_FLOOR_RST = 16'd0;
  localparam logic [15:0] ANGLE_CEIL_RST  = 16'd18000;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_FLOOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_CEIL  = 1'b1;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_VERLEN  = 4'd1,
    PH_SPD_LO  = 4'd2,
    PH_SPD_HI  = 4'd3,
    PH_SA_LO   = 4'd4,
    PH_SA_HI   = 4'd5,
    PH_DIST_LO = 4'd6,
    PH_DIST_HI = 4'd7,
    PH_INTENS  = 4'd8,
    PH_EA_LO   = 4'd9,
    PH_EA_HI   = 4'd10,
    PH_TS_LO   = 4'd11,
    PH_TS_HI   = 4'd12,
    PH_CHECK   = 4'd13
  } phase_t;

  // One queued job for the emitter: an error result or a frame burst.
  typedef struct packed {
    logic        is_error;
    logic [15:0] speed;
    logic [15:0] angle_open;
    logic [15:0] angle_close;
    logic [15:0] stamp;
  } lfp_cmd_t;

  typedef struct packed {
    logic [7:0]  intensity;
    logic [15:0] distance;
  } lfp_point_t;

  // Status the emitter reports back to the parser.
  typedef struct packed {
    logic                active;
    logic [PT_IDX_W-1:0] rd_idx;
  } lfp_emit_stat_t;

  // CRC-8, MSB first, one byte per call.
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* rtl/lfp_in_if.sv */
interface lfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/lfp_out_if.sv */
interface lfp_out_if;
  logic        valid;
  logic        ready;
  logic        frame_status;
  logic [15:0] rot_speed;
  logic [15:0] first_angle;
  logic [15:0] final_angle;
  logic [15:0] stamp_ms;
  logic [3:0]  point_number;
  logic [15:0] range_value;
  logic [7:0]  echo_strength;
  logic        last_point;

  modport source (
    output valid, output frame_status, output rot_speed, output first_angle,
    output final_angle, output stamp_ms, output point_number, output range_value,
    output echo_strength, output last_point, input ready
  );
  modport sink (
    input valid, input frame_status, input rot_speed, input first_angle,
    input final_angle, input stamp_ms, input point_number, input range_value,
    input echo_strength, input last_point, output ready
  );
endinterface

/* rtl/lfp_parser.sv */
module lfp_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  lfp_in_if.sink                              in_ch,
  input  logic                                cfg_we,
  input  logic [lfp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lfp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                q_full,
  input  logic                                emit_busy,
  input  lfp_pkg::lfp_emit_stat_t             emit_stat,
  output logic                                q_push,
  output lfp_pkg::lfp_cmd_t                   q_wdata,
  output lfp_pkg::lfp_point_t                 rd_data
);
  import lfp_pkg::*;

  phase_t       phase_r, phase_nxt;
  logic [7:0]   crc_r, crc_nxt;
  logic [15:0]  speed_r, speed_nxt;
  logic [15:0]  sa_r, sa_nxt;
  logic [15:0]  ea_r, ea_nxt;
  logic [15:0]  ts_r, ts_nxt;
  logic [PT_NUM_W-1:0] count_r, count_nxt;
  logic [15:0]  floor_r, ceil_r;
  lfp_point_t   store_r [POINTS_PER_FRAME];

  logic         in_fire;
  logic         point_phase;
  logic [7:0]   b;
  logic [PT_IDX_W-1:0] slot;

  assign b           = in_ch.rx_byte;
  assign slot        = count_r[PT_IDX_W-1:0];
  assign point_phase = (phase_r == PH_DIST_LO) || (phase_r == PH_DIST_HI) ||
                       (phase_r == PH_INTENS);
  // hold the byte while the job queue is full or while the emitter still reads the store
  assign in_ch.ready = !q_full && !(point_phase && emit_busy);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign rd_data     = store_r[emit_stat.rd_idx];

  always_comb begin
    phase_nxt = phase_r;
    crc_nxt   = crc_r;
    speed_nxt = speed_r;
    sa_nxt    = sa_r;
    ea_nxt    = ea_r;
    ts_nxt    = ts_r;
    count_nxt = count_r;
    q_push    = 1'b0;
    q_wdata   = '{is_error: 1'b0, speed: speed_r, angle_open: sa_r,
                  angle_close: ea_r, stamp: ts_r};
    if (in_fire) begin
      if (phase_r != PH_CHECK) begin
        crc_nxt = crc8_next(crc_r, b);
      end
      unique case (phase_r)
        PH_HEADER: begin
          if (b == HDR_BYTE) begin
            phase_nxt = PH_VERLEN;
            crc_nxt   = crc8_next(8'h00, HDR_BYTE);
          end
        end
        PH_VERLEN: begin
          if (b[7:5] != VERSION_CODE) begin
            phase_nxt        = PH_HEADER;
            q_push           = 1'b1;
            q_wdata.is_error = 1'b1;
          end else begin
            phase_nxt = PH_SPD_LO;
          end
        end
        PH_SPD_LO: begin
          speed_nxt = {8'h00, b};
          phase_nxt = PH_SPD_HI;
        end
        PH_SPD_HI: begin
          speed_nxt = {b, speed_r[7:0]};
          phase_nxt = PH_SA_LO;
        end
        PH_SA_LO: begin
          sa_nxt    = {8'h00, b};
          phase_nxt = PH_SA_HI;
        end
        PH_SA_HI: begin
          sa_nxt    = {b, sa_r[7:0]};
          count_nxt = '0;
          phase_nxt = PH_DIST_LO;
        end
        PH_DIST_LO: phase_nxt = PH_DIST_HI;
        PH_DIST_HI: phase_nxt = PH_INTENS;
        PH_INTENS: begin
          count_nxt = count_r + PT_NUM_W'(1);
          phase_nxt = (count_nxt >= PT_NUM_W'(POINTS_PER_FRAME)) ? PH_EA_LO : PH_DIST_LO;
        end
        PH_EA_LO: begin
          ea_nxt    = {8'h00, b};
          phase_nxt = PH_EA_HI;
        end
        PH_EA_HI: begin
          ea_nxt    = {b, ea_r[7:0]};
          phase_nxt = PH_TS_LO;
        end
        PH_TS_LO: begin
          ts_nxt    = {8'h00, b};
          phase_nxt = PH_TS_HI;
        end
        PH_TS_HI: begin
          ts_nxt    = {b, ts_r[7:0]};
          phase_nxt = PH_CHECK;
        end
        PH_CHECK: begin
          phase_nxt = PH_HEADER;
          if (b != crc_r) begin
            q_push           = 1'b1;
            q_wdata.is_error = 1'b1;
          end else if ((sa_r < ceil_r) && (sa_r > floor_r)) begin
            q_push = 1'b1;
          end
        end
        default: phase_nxt = PH_HEADER;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      crc_r   <= '0;
      speed_r <= '0;
      sa_r    <= '0;
      ea_r    <= '0;
      ts_r    <= '0;
      count_r <= '0;
      floor_r <= ANGLE_FLOOR_RST;
      ceil_r  <= ANGLE_CEIL_RST;
    end else begin
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      speed_r <= speed_nxt;
      sa_r    <= sa_nxt;
      ea_r    <= ea_nxt;
      ts_r    <= ts_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ANGLE_FLOOR: floor_r <= cfg_wdata;
          CFG_ANGLE_CEIL:  ceil_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // point store: one byte lane per phase
  always_ff @(posedge clk) begin
    if (in_fire) begin
      case (phase_r)
        PH_DIST_LO: store_r[slot].distance[7:0]  <= b;
        PH_DIST_HI: store_r[slot].distance[15:8] <= b;
        PH_INTENS:  store_r[slot].intensity      <= b;
        default: ;
      endcase
    end
  end

  a_no_write_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && point_phase) |-> !emit_busy)
    else $error("point store written while the emitter reads it");

  a_check_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == PH_CHECK) |=> (phase_r == PH_HEADER))
    else $error("parser did not return to header hunt after check byte");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

endmodule

/* rtl/lfp_cmd_queue.sv */
module lfp_cmd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lfp_pkg::lfp_cmd_t  wdata,
  input  logic               pop,
  output lfp_pkg::lfp_cmd_t  rdata,
  output logic               not_empty,
  output logic               full
);
  import lfp_pkg::*;

  lfp_cmd_t              mem_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_CNT_W-1:0] count_r;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign rdata     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + CMDQ_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + CMDQ_PTR_W'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + CMDQ_CNT_W'(1);
        2'b01:   count_r <= count_r - CMDQ_CNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CMDQ_CNT_W'(CMDQ_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> !full)
    else $error("push into full queue");

endmodule

/* rtl/lfp_emitter.sv */
module lfp_emitter (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_not_empty,
  input  lfp_pkg::lfp_cmd_t        q_rdata,
  output logic                     q_pop,
  output lfp_pkg::lfp_emit_stat_t  stat,
  input  lfp_pkg::lfp_point_t      rd_data,
  lfp_out_if.source                out_ch
);
  import lfp_pkg::*;

  logic                active_r;
  lfp_cmd_t            job_r;
  logic [PT_IDX_W-1:0] idx_r;
  logic                can_load;
  logic                last_pt;

  logic        out_valid_r;
  logic        status_r;
  logic [15:0] speed_r, first_r, final_r, stamp_r, range_r;
  logic [3:0]  num_r;
  logic [7:0]  echo_r;
  logic        last_r;

  assign can_load    = !out_valid_r || out_ch.ready;
  assign last_pt     = (idx_r == PT_IDX_W'(POINTS_PER_FRAME - 1));
  assign q_pop       = !active_r && q_not_empty;
  assign stat.active = active_r;
  assign stat.rd_idx = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        active_r <= 1'b1;
        idx_r    <= '0;
        job_r    <= q_rdata;
      end else if (active_r && can_load) begin
        out_valid_r <= 1'b1;
        if (job_r.is_error) begin
          status_r <= 1'b1;
          speed_r  <= '0;
          first_r  <= '0;
          final_r  <= '0;
          stamp_r  <= '0;
          num_r    <= '0;
          range_r  <= '0;
          echo_r   <= '0;
          last_r   <= 1'b1;
          active_r <= 1'b0;
        end else begin
          status_r <= 1'b0;
          speed_r  <= job_r.speed;
          first_r  <= job_r.angle_open;
          final_r  <= job_r.angle_close;
          stamp_r  <= job_r.stamp;
          num_r    <= 4'(idx_r);
          range_r  <= rd_data.distance;
          echo_r   <= rd_data.intensity;
          last_r   <= last_pt;
          idx_r    <= idx_r + PT_IDX_W'(1);
          if (last_pt) active_r <= 1'b0;
        end
      end
      if (can_load && !(active_r && !q_pop)) out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.frame_status  = status_r;
  assign out_ch.rot_speed     = speed_r;
  assign out_ch.first_angle   = first_r;
  assign out_ch.final_angle   = final_r;
  assign out_ch.stamp_ms      = stamp_r;
  assign out_ch.point_number  = num_r;
  assign out_ch.range_value   = range_r;
  assign out_ch.echo_strength = echo_r;
  assign out_ch.last_point    = last_r;

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r) |-> last_r)
    else $error("error result without last mark");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (idx_r <= PT_IDX_W'(POINTS_PER_FRAME - 1)))
    else $error("point index beyond frame");

  a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && can_load && !job_r.is_error && last_pt) |=> !active_r)
    else $error("emitter still active after last point");

endmodule

/* rtl/lidar_frame_parser_crc8.sv */
// Serial lidar frame parser: takes one received byte per item on in_ch, hunts for the
// 0x54 header, checks the version bits, gathers speed, start angle, twelve points,
// end angle and timestamp, and checks the CRC-8 (poly 0x4D) against the closing byte.
// A version or CRC failure gives one error item with last_point set; a good frame whose
// start angle lies strictly between angle_floor (cfg index 0) and angle_ceiling (index 1)
// gives one item per point, the last marked; any other good frame gives nothing.
// The parser takes one byte per cycle unless it holds its input. A frame burst leaves
// the output register at one item per cycle while out_ch.ready is high; while a burst is
// queued or draining the parser holds bytes that would land in the point store, so a
// frame's point bytes wait on the previous burst. A two-entry job queue sits between
// parser and emitter; the parser also holds its input whenever that queue is full.
module lidar_frame_parser_crc8 (
  input  logic                           clk,
  input  logic                           rst_n,
  lfp_in_if.sink                         in_ch,
  lfp_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [lfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lfp_pkg::*;

  logic           q_push, q_pop, q_not_empty, q_full;
  lfp_cmd_t       q_wdata, q_rdata;
  lfp_point_t     rd_data;
  lfp_emit_stat_t emit_stat;
  logic           emit_busy;

  // a queued or running job may still need the point store
  assign emit_busy = emit_stat.active || q_not_empty;

  lfp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .emit_busy (emit_busy),
    .emit_stat (emit_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata),
    .rd_data   (rd_data)
  );

  lfp_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  lfp_emitter u_emitter (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .stat        (emit_stat),
    .rd_data     (rd_data),
    .out_ch      (out_ch)
  );

endmodule

/* tb/sv/lidar_frame_parser_crc8_tb.sv */
module lidar_frame_parser_crc8_tb;
  import lfp_pkg::*;

  // Wait this long after the last due item before a register write or the end,
  // so that a frame that gives no items has left the parser and job queue.
  localparam int SETTLE_CYCLES = 40;

  // Content of the twelve point slots of a composed frame.
  typedef enum {PTS_RANDOM, PTS_ZERO, PTS_FULL} pts_fill_t;
  // Kind of closing byte: correct CRC, corrupted CRC, or a header byte in its place.
  typedef enum {CHK_GOOD, CHK_FLIP, CHK_AS_HEADER} check_kind_t;

  // One result item as the block should present it.
  typedef struct packed {
    logic        status;
    logic [15:0] speed;
    logic [15:0] ang_first;
    logic [15:0] ang_last;
    logic [15:0] stamp;
    logic [3:0]  idx;
    logic [15:0] rng;
    logic [7:0]  inten;
    logic        last_flag;
  } point_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lfp_in_if  in_ch ();
  lfp_out_if out_ch ();

  lidar_frame_parser_crc8 u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Frame parser mirror: the state the block should hold after each accepted byte
  // ---------------------------------------------------------------------------
  logic [7:0]  crc_lut [256];
  phase_t      ph = PH_HEADER;
  logic [7:0]  crc_run = 8'h00;
  logic [15:0] spd = '0;
  logic [15:0] ang_start = '0;
  logic [15:0] ang_end = '0;
  logic [15:0] stamp_v = '0;
  logic [3:0]  pt_cnt = '0;
  logic [23:0] pt_mem [POINTS_PER_FRAME];
  logic [15:0] win_floor = ANGLE_FLOOR_RST;
  logic [15:0] win_ceil = ANGLE_CEIL_RST;

  point_result_t results_due [$];

  int unsigned bytes_sent;
  int unsigned frames_sent;
  int unsigned results_promised;
  int unsigned point_items_due;
  int unsigned error_items_due;
  int unsigned dropped_frames;
  int unsigned mismatches;
  bit          steady;

  function automatic void queue_error_item();
    point_result_t r;
    r = '0;
    r.status = 1'b1;
    r.last_flag = 1'b1;
    results_due.push_back(r);
    results_promised++;
    error_items_due++;
  endfunction

  // Advance the mirror by one received byte and queue whatever items it causes.
  function automatic void predict_byte(input logic [7:0] b);
    point_result_t r;
    int s;
    s = (pt_cnt < POINTS_PER_FRAME) ? int'(pt_cnt) : POINTS_PER_FRAME - 1;
    // The closing byte is compared, not folded in.
    if (ph != PH_CHECK) crc_run = crc_lut[crc_run ^ b];
    case (ph)
      PH_HEADER: begin
        // Anything but the header is dropped; the header restarts the CRC.
        if (b == HDR_BYTE) begin
          ph = PH_VERLEN;
          crc_run = crc_lut[HDR_BYTE];
        end
      end
      PH_VERLEN: begin
        if (b[7:5] != VERSION_CODE) begin
          ph = PH_HEADER;
          queue_error_item();
        end else begin
          ph = PH_SPD_LO;
        end
      end
      PH_SPD_LO: begin spd = {8'h00, b}; ph = PH_SPD_HI; end
      PH_SPD_HI: begin spd[15:8] = b; ph = PH_SA_LO; end
      PH_SA_LO:  begin ang_start = {8'h00, b}; ph = PH_SA_HI; end
      PH_SA_HI: begin
        ang_start[15:8] = b;
        pt_cnt = '0;
        ph = PH_DIST_LO;
      end
      PH_DIST_LO: begin pt_mem[s] = {pt_mem[s][23:16], 8'h00, b}; ph = PH_DIST_HI; end
      PH_DIST_HI: begin pt_mem[s][15:8] = b; ph = PH_INTENS; end
      PH_INTENS: begin
        pt_mem[s][23:16] = b;
        pt_cnt = pt_cnt + 4'd1;
        if (pt_cnt >= POINTS_PER_FRAME) ph = PH_EA_LO;
        else ph = PH_DIST_LO;
      end
      PH_EA_LO: begin ang_end = {8'h00, b}; ph = PH_EA_HI; end
      PH_EA_HI: begin ang_end[15:8] = b; ph = PH_TS_LO; end
      PH_TS_LO: begin stamp_v = {8'h00, b}; ph = PH_TS_HI; end
      PH_TS_HI: begin stamp_v[15:8] = b; ph = PH_CHECK; end
      PH_CHECK: begin
        ph = PH_HEADER;
        if (b != crc_run) begin
          queue_error_item();
        end else if (ang_start < win_ceil && ang_start > win_floor) begin
          for (int k = 0; k < POINTS_PER_FRAME; k++) begin
            r = '0;
            r.speed = spd;
            r.ang_first = ang_start;
            r.ang_last = ang_end;
            r.stamp = stamp_v;
            r.idx = 4'(k);
            r.rng = pt_mem[k][15:0];
            r.inten = pt_mem[k][23:16];
            r.last_flag = (k == POINTS_PER_FRAME - 1);
            results_due.push_back(r);
            results_promised++;
            point_items_due++;
          end
        end else begin
          dropped_frames++;
        end
      end
      default: ph = PH_HEADER;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    // Cap the log; the count still grows.
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  // Compare every accepted item, field by field, with the oldest due item.
  always @(posedge clk) begin : result_check
    point_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (results_due.size() == 0) begin
        report_mismatch("result item with nothing due");
      end else begin
        want = results_due.pop_front();
        check_field("frame_status", 16'(out_ch.frame_status), 16'(want.status));
        check_field("rot_speed", out_ch.rot_speed, want.speed);
        check_field("first_angle", out_ch.first_angle, want.ang_first);
        check_field("final_angle", out_ch.final_angle, want.ang_last);
        check_field("stamp_ms", out_ch.stamp_ms, want.stamp);
        check_field("point_number", 16'(out_ch.point_number), 16'(want.idx));
        check_field("range_value", out_ch.range_value, want.rng);
        check_field("echo_strength", 16'(out_ch.echo_strength), 16'(want.inten));
        check_field("last_point", 16'(out_ch.last_point), 16'(want.last_flag));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Idling on both sides
  // ---------------------------------------------------------------------------
  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver: bursts of ready broken by stalls; hold ready high in steady stretches.
  initial begin : sink_ready
    int n;
    forever begin
      out_ch.ready <= 1'b1;
      if (steady) begin
        @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk);
        n = pick_gap();
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Offer one byte after a random gap and hold it until accepted. Valid is left
  // high so that a back-to-back byte needs no second assignment in the same step.
  task automatic push_rx_byte(input logic [7:0] b);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_byte(b);
    bytes_sent++;
  endtask

  // Drop valid and hold off until every due item has come, then let the parser settle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    if (idx == CFG_ANGLE_FLOOR) win_floor = v;
    else win_ceil = v;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(input logic [15:0] lo, input logic [15:0] hi);
    write_reg(CFG_ANGLE_FLOOR, lo);
    write_reg(CFG_ANGLE_CEIL, hi);
  endtask

  function automatic logic [7:0] version_byte(input bit good);
    logic [7:0] v;
    v = 8'($urandom);
    if (good) v[7:5] = VERSION_CODE;
    else while (v[7:5] == VERSION_CODE) v = 8'($urandom);
    return v;
  endfunction

  // Start angle: mostly inside the window, some on its edges, some anywhere.
  function automatic logic [15:0] pick_start_angle();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6 && win_ceil > win_floor + 1) return 16'($urandom_range(win_floor + 1, win_ceil - 1));
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0: return win_floor;
        1: return win_ceil;
        2: return win_floor + 16'd1;
        default: return win_ceil - 16'd1;
      endcase
    end
    return 16'($urandom);
  endfunction

  // Compose a frame and send it; cut > 0 sends only that many leading bytes.
  task automatic send_frame(input logic [7:0] ver, input logic [15:0] spd_v,
                            input logic [15:0] sa, input logic [15:0] ea,
                            input logic [15:0] ts, input pts_fill_t fill,
                            input check_kind_t chk, input int cut);
    logic [7:0]  q [$];
    logic [7:0]  acc;
    logic [23:0] p;
    int n;
    q.push_back(HDR_BYTE);
    q.push_back(ver);
    q.push_back(spd_v[7:0]);
    q.push_back(spd_v[15:8]);
    q.push_back(sa[7:0]);
    q.push_back(sa[15:8]);
    for (int k = 0; k < POINTS_PER_FRAME; k++) begin
      case (fill)
        PTS_ZERO: p = '0;
        PTS_FULL: p = '1;
        default:  p = 24'($urandom);
      endcase
      q.push_back(p[7:0]);
      q.push_back(p[15:8]);
      q.push_back(p[23:16]);
    end
    q.push_back(ea[7:0]);
    q.push_back(ea[15:8]);
    q.push_back(ts[7:0]);
    q.push_back(ts[15:8]);
    acc = 8'h00;
    foreach (q[i]) acc = crc_lut[acc ^ q[i]];
    case (chk)
      CHK_GOOD: q.push_back(acc);
      CHK_FLIP: q.push_back(acc ^ 8'($urandom_range(1, 255)));
      default:  q.push_back(HDR_BYTE);
    endcase
    n = (cut > 0 && cut < q.size()) ? cut : q.size();
    frames_sent++;
    for (int i = 0; i < n; i++) push_rx_byte(q[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Bytes ahead of a header, including near misses of it, must be dropped.
  task automatic test_header_hunt();
    logic [7:0] noise [7];
    noise = '{8'h00, 8'hFF, 8'h53, 8'h55, 8'hD4, 8'h14, 8'hAB};
    foreach (noise[i]) push_rx_byte(noise[i]);
    send_frame(version_byte(1), 16'd3600, 16'd9000, 16'd12000, 16'd777, PTS_RANDOM, CHK_GOOD, 0);
  endtask

  // Every wrong version code gives one error item and a fresh header hunt.
  task automatic test_version_codes();
    for (int v = 0; v < 8; v++) begin
      if (3'(v) != VERSION_CODE) begin
        push_rx_byte(HDR_BYTE);
        push_rx_byte({3'(v), 5'($urandom)});
      end
    end
  endtask

  // All-zero and all-ones field contents, then the widest window.
  task automatic test_field_extremes();
    send_frame({VERSION_CODE, 5'h00}, 16'h0000, 16'd1, 16'h0000, 16'h0000,
               PTS_ZERO, CHK_GOOD, 0);
    send_frame({VERSION_CODE, 5'h1F}, 16'hFFFF, ANGLE_CEIL_RST - 16'd1, 16'hFFFF, 16'hFFFF,
               PTS_FULL, CHK_GOOD, 0);
    drain_results();
    set_window(16'h0000, 16'hFFFF);
    send_frame(version_byte(1), 16'($urandom), 16'hFFFE, 16'($urandom), 16'($urandom),
               PTS_RANDOM, CHK_GOOD, 0);
    send_frame(version_byte(1), 16'($urandom), 16'h0000, 16'($urandom), 16'($urandom),
               PTS_RANDOM, CHK_GOOD, 0);
  endtask

  // A corrupted check byte gives one error item; a check byte that happens to be
  // the header value must not open a new frame, so the byte after it is dropped.
  task automatic test_crc_errors();
    send_frame(version_byte(1), 16'($urandom), 16'd4000, 16'($urandom), 16'($urandom),
               PTS_RANDOM, CHK_FLIP, 0);
    send_frame(version_byte(1), 16'($urandom), 16'd4000, 16'($urandom), 16'($urandom),
               PTS_RANDOM, CHK_AS_HEADER, 0);
    push_rx_byte({VERSION_CODE, 5'h0A});
    send_frame(version_byte(1), 16'($urandom), 16'd4001, 16'($urandom), 16'($urandom),
               PTS_RANDOM, CHK_GOOD, 0);
  endtask

  // Both window edges are exclusive; an empty or inverted window passes nothing.
  task automatic test_window_edges();
    logic [15:0] starts [4];
    starts = '{16'd1000, 16'd1001, 16'd1999, 16'd2000};
    drain_results();
    set_window(16'd1000, 16'd2000);
    foreach (starts[i])
      send_frame(version_byte(1), 16'($urandom), starts[i], 16'($urandom), 16'($urandom),
                 PTS_RANDOM, CHK_GOOD, 0);
    drain_results();
    set_window(16'd500, 16'd501);
    send_frame(version_byte(1), 16'($urandom), 16'd500, 16'($urandom), 16'($urandom),
               PTS_RANDOM, CHK_GOOD, 0);
    send_frame(version_byte(1), 16'($urandom), 16'd501, 16'($urandom), 16'($urandom),
               PTS_RANDOM, CHK_GOOD, 0);
    drain_results();
    set_window(16'hFFFF, 16'h0000);
    send_frame(version_byte(1), 16'($urandom), 16'd32768, 16'($urandom), 16'($urandom),
               PTS_RANDOM, CHK_GOOD, 0);
    drain_results();
    set_window(ANGLE_FLOOR_RST, ANGLE_CEIL_RST);
  endtask

  // Mostly well-formed frames with random content under a fresh window per phase;
  // the rest bad versions, bad CRCs, cut-off frames and stray bytes. The second
  // phase runs with no idling on either side.
  task automatic test_random_traffic();
    int unsigned byte_mark, result_mark, phase_mark;
    int r, phase_no;
    logic [15:0] lo, hi;
    byte_mark = bytes_sent;
    result_mark = results_promised;
    phase_no = 0;
    while (bytes_sent - byte_mark < 320 || results_promised - result_mark < 48) begin
      drain_results();
      case ($urandom_range(0, 5))
        0: begin lo = 16'h0000; hi = 16'hFFFF; end
        1: begin lo = 16'($urandom); hi = lo + 16'($urandom_range(0, 1)); end
        default: begin
          lo = 16'($urandom_range(0, 30000));
          hi = lo + 16'($urandom_range(2, 35535));
        end
      endcase
      set_window(lo, hi);
      steady = (phase_no == 1);
      phase_mark = bytes_sent;
      while (bytes_sent - phase_mark < 80) begin
        r = $urandom_range(0, 99);
        if (r < 68) begin
          send_frame(version_byte(1), 16'($urandom), pick_start_angle(), 16'($urandom),
                     16'($urandom), PTS_RANDOM, CHK_GOOD, 0);
        end else if (r < 78) begin
          send_frame(version_byte(0), 16'($urandom), pick_start_angle(), 16'($urandom),
                     16'($urandom), PTS_RANDOM, CHK_GOOD, $urandom_range(0, 1) ? 2 : 0);
        end else if (r < 86) begin
          send_frame(version_byte(1), 16'($urandom), pick_start_angle(), 16'($urandom),
                     16'($urandom), PTS_RANDOM, CHK_FLIP, 0);
        end else if (r < 93) begin
          send_frame(version_byte(1), 16'($urandom), pick_start_angle(), 16'($urandom),
                     16'($urandom), PTS_RANDOM, CHK_GOOD, $urandom_range(2, 46));
        end else begin
          repeat ($urandom_range(1, 4)) push_rx_byte(8'($urandom));
        end
        // Now and then hold the sender until every due item has drained.
        if ($urandom_range(0, 11) == 0) drain_results();
      end
      steady = 1'b0;
      phase_no++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    logic [7:0] c;
    // Build the CRC-8 lookup, MSB first.
    for (int v = 0; v < 256; v++) begin
      c = 8'(v);
      for (int i = 0; i < 8; i++) c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      crc_lut[v] = c;
    end
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_ANGLE_FLOOR;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.rx_byte <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_header_hunt();
    test_version_codes();
    test_field_extremes();
    test_crc_errors();
    test_window_edges();
    test_random_traffic();
    drain_results();

    $display("Run covered %0d bytes over %0d frame attempts and several angle windows.",
             bytes_sent, frames_sent);
    $display("Checked %0d point items and %0d error items; %0d good frames lay outside the window.",
             point_items_due, error_items_due, dropped_frames);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
